### hdl/sbon_pkg.sv
// Package with shared constants and types for the sheared box overlap block.
package sbon_pkg;
	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF = 10;
	localparam int DEPTH_W = 20;

	typedef enum logic [2:0] {
		N_NONE = 3'd0,
		N_NEG_X = 3'd1,
		N_POS_X = 3'd2,
		N_NEG_Y = 3'd3,
		N_POS_Y = 3'd4,
		N_NEG_Z = 3'd5,
		N_POS_Z = 3'd6
	} normal_t;
endpackage

### hdl/sbon_div.sv
// Pipelined restoring signed divider, one quotient bit per stage, truncating toward zero.
module sbon_div
	import sbon_pkg::*;
#(
	parameter int NW = 42,
	parameter int DW = 21,
	parameter int TW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic        [TW-1:0] tag,
	output logic                 out_valid,
	output logic signed [NW-1:0] quo,
	output logic        [TW-1:0] out_tag
);
	localparam int RW = DW + 1;

	logic          vld_q [0:NW];
	logic [NW-1:0] n_q   [0:NW];
	logic [DW-1:0] d_q   [0:NW];
	logic [RW-1:0] r_q   [0:NW];
	logic          neg_q [0:NW];
	logic [TW-1:0] tag_q [0:NW];

	always_comb begin
		vld_q[0] = in_valid;
		n_q[0] = num[NW-1] ? NW'(-num) : NW'(num);
		d_q[0] = den[DW-1] ? DW'(-den) : DW'(den);
		r_q[0] = '0;
		neg_q[0] = num[NW-1] ^ den[DW-1];
		tag_q[0] = tag;
	end

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [RW-1:0] sh;
		logic [RW-1:0] df;
		logic          ge;
		assign sh = {r_q[i][RW-2:0], n_q[i][NW-1]};
		assign df = sh - {1'b0, d_q[i]};
		assign ge = (sh >= {1'b0, d_q[i]});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[i+1] <= 1'b0;
			else vld_q[i+1] <= vld_q[i];
		end
		always_ff @(posedge clk) begin
			r_q[i+1] <= ge ? df : sh;
			n_q[i+1] <= {n_q[i][NW-2:0], ge};
			d_q[i+1] <= d_q[i];
			neg_q[i+1] <= neg_q[i];
			tag_q[i+1] <= tag_q[i];
		end
	end

	assign out_valid = vld_q[NW];
	assign quo = neg_q[NW] ? NW'(-n_q[NW]) : n_q[NW];
	assign out_tag = tag_q[NW];
endmodule

### hdl/sheared_box_overlap_normal.sv
// Top level of the sheared box overlap and minimum penetration axis block.
// Throughput: one request per cycle; busy is always low, the divider is fully pipelined.
// The two shear divisions each take one restoring step per stage; that chain sets latency.
// Reset (arst_n low) clears all valid bits at once; payload registers hold no reset.
// The receiver cannot stall, so every result shows for exactly one cycle on done.
module sheared_box_overlap_normal
	import sbon_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [3*COORD_BITS-1:0]  first_min,
	input  logic [3*COORD_BITS-1:0]  first_max,
	input  logic [2*COORD_BITS-1:0]  first_pos_xz,
	input  logic [3*COORD_BITS-1:0]  second_min,
	input  logic [3*COORD_BITS-1:0]  second_max,
	input  logic [2*COORD_BITS-1:0]  shear_along_x,
	input  logic [2*COORD_BITS-1:0]  shear_along_z,
	output logic                     done,
	output logic                     hit,
	output logic [2:0]               normal_code,
	output logic signed [DEPTH_W-1:0] depth,
	output logic                     extent_zero
);
	localparam int C = COORD_BITS;
	// A difference of two coordinates needs one more bit; a product of two needs twice that.
	localparam int DW = C + 1;
	localparam int NW = 2 * DW;
	localparam int TW = 1;
	// The depth search must hold both a depth and the starting value of ten.
	localparam int XW = (C + 3 > FRAC_BITS + 6) ? C + 3 : FRAC_BITS + 6;
	// The raised top adds two full quotients to a coordinate before saturation.
	localparam int TSW = NW + 2;
	localparam logic signed [XW-1:0] CMAX = XW'((1 << (C - 1)) - 1);
	localparam logic signed [XW-1:0] CMIN = XW'(-(1 << (C - 1)));
	localparam logic signed [XW-1:0] TEN = XW'(10 << FRAC_BITS);

	typedef struct packed {
		logic [3*C-1:0] amin;
		logic [3*C-1:0] amax;
		logic [3*C-1:0] bmin;
		logic [3*C-1:0] bmax;
		logic [C-1:0]   s0x;
		logic [C-1:0]   s0z;
		logic           zx;
		logic           zz;
	} box_t;

	function automatic logic signed [C-1:0] crd(input logic [3*C-1:0] w, input int k);
		crd = w[k*C +: C];
	endfunction

	// The block never refuses a request.
	assign busy = 1'b0;

	// Stage 1: differences of the position, extent and shear inputs.
	logic              v_s1;
	box_t              b_s1;
	logic signed [DW-1:0] px_s1, ex_s1, dsx_s1, pz_s1, ez_s1, dsz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		b_s1.amin <= first_min;
		b_s1.amax <= first_max;
		b_s1.bmin <= second_min;
		b_s1.bmax <= second_max;
		b_s1.s0x <= shear_along_x[C-1:0];
		b_s1.s0z <= shear_along_z[C-1:0];
		b_s1.zx <= (second_max[C-1:0] == second_min[C-1:0]);
		b_s1.zz <= (second_max[3*C-1:2*C] == second_min[3*C-1:2*C]);
		px_s1 <= DW'(signed'(first_pos_xz[C-1:0])) - DW'(crd(second_min, 0));
		ex_s1 <= DW'(crd(second_max, 0)) - DW'(crd(second_min, 0));
		dsx_s1 <= DW'(signed'(shear_along_x[2*C-1:C])) - DW'(signed'(shear_along_x[C-1:0]));
		pz_s1 <= DW'(signed'(first_pos_xz[2*C-1:C])) - DW'(crd(second_min, 2));
		ez_s1 <= DW'(crd(second_max, 2)) - DW'(crd(second_min, 2));
		dsz_s1 <= DW'(signed'(shear_along_z[2*C-1:C])) - DW'(signed'(shear_along_z[C-1:0]));
	end

	// Stage 2: products of position offset and shear rise.
	logic              v_s2;
	box_t              b_s2;
	logic signed [NW-1:0] nx_s2, nz_s2;
	logic signed [DW-1:0] ex_s2, ez_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		b_s2 <= b_s1;
		nx_s2 <= NW'(px_s1) * NW'(dsx_s1);
		nz_s2 <= NW'(pz_s1) * NW'(dsz_s1);
		// A zero extent divides by one; the quotient is then replaced by zero.
		ex_s2 <= b_s1.zx ? DW'(1) : ex_s1;
		ez_s2 <= b_s1.zz ? DW'(1) : ez_s1;
	end

	// The box payload rides along a shift line matched to the divider depth.
	box_t              bl_q [0:NW];
	always_comb bl_q[0] = b_s2;
	for (genvar i = 0; i < NW; i++) begin : g_line
		always_ff @(posedge clk) bl_q[i+1] <= bl_q[i];
	end

	logic                 qv_x, qv_z;
	logic signed [NW-1:0] qx, qz;
	logic [TW-1:0]        zt_x, zt_z;

	// Each divider carries its own zero-extent flag alongside the quotient.
	sbon_div #(.NW(NW), .DW(DW), .TW(TW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .num(nx_s2), .den(ex_s2),
		.tag(b_s2.zx), .out_valid(qv_x), .quo(qx), .out_tag(zt_x)
	);
	sbon_div #(.NW(NW), .DW(DW), .TW(TW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .num(nz_s2), .den(ez_s2),
		.tag(b_s2.zz), .out_valid(qv_z), .quo(qz), .out_tag(zt_z)
	);

	box_t bd;
	assign bd = bl_q[NW];

	// Stage 3: raised top with saturation. The full quotient is kept, since a tiny
	// extent can make it far larger than a coordinate.
	logic              v_s3;
	box_t              b_s3;
	logic signed [C-1:0] top_s3;
	logic signed [TSW-1:0] tx, tz, tsum;

	always_comb begin
		tx = zt_x[0] ? TSW'(signed'(bd.s0x)) : TSW'(signed'(bd.s0x)) + TSW'(qx);
		tz = zt_z[0] ? TSW'(signed'(bd.s0z)) : TSW'(signed'(bd.s0z)) + TSW'(qz);
		tsum = TSW'(crd(bd.bmax, 1)) + tx + tz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= qv_x & qv_z;
	end

	always_ff @(posedge clk) begin
		b_s3 <= bd;
		top_s3 <= (tsum > CMAX) ? CMAX[C-1:0] : (tsum < CMIN) ? CMIN[C-1:0] : tsum[C-1:0];
	end

	// Stage 4: the six depths and the overlap test.
	logic              v_s4;
	logic              hit_s4, ez_s4;
	logic signed [DW-1:0] d_s4 [0:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		logic ok;
		logic signed [C-1:0] bx;
		ok = 1'b1;
		for (int k = 0; k < 3; k++) begin
			bx = (k == 1) ? top_s3 : crd(b_s3.bmax, k);
			if (!(crd(b_s3.amax, k) >= crd(b_s3.bmin, k) && crd(b_s3.amin, k) <= bx))
				ok = 1'b0;
			d_s4[2*k] <= DW'(crd(b_s3.amax, k)) - DW'(crd(b_s3.bmin, k));
			d_s4[2*k+1] <= DW'(bx) - DW'(crd(b_s3.amin, k));
		end
		hit_s4 <= ok;
		ez_s4 <= b_s3.zx | b_s3.zz;
	end

	// Stage 5: minimum search in order, strict less-than keeps the earlier axis.
	logic signed [XW-1:0] best;
	logic [2:0]           code;
	always_comb begin
		best = TEN;
		code = N_NONE;
		for (int k = 0; k < 6; k++) begin
			if (XW'(d_s4[k]) < best) begin
				best = XW'(d_s4[k]);
				code = 3'(k + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s4;
	end

	always_ff @(posedge clk) begin
		hit <= hit_s4;
		extent_zero <= ez_s4;
		normal_code <= code;
		depth <= (best > CMAX) ? DEPTH_W'(CMAX) : (best < CMIN) ? DEPTH_W'(CMIN) : DEPTH_W'(best);
	end
endmodule
